/* src/nonlinear_flux_observer_top_macros.svh */
// Assertion macros shared by the flux observer design.
`ifndef NONLINEAR_FLUX_OBSERVER_TOP_MACROS_SVH
`define NONLINEAR_FLUX_OBSERVER_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define NFO_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("nfo assertion failed");

// Next-cycle implication, checked outside reset.
`define NFO_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("nfo assertion failed");

`endif

/* src/nfo_pkg.sv */
// Shared types, constants and tables of the flux observer.
package nfo_pkg;

    localparam int IN_W        = 24;
    localparam int OUT_W       = 16;
    localparam int FLUX_W      = 40;
    localparam int CFG_W       = 40;
    localparam int CFG_IDX_W   = 3;
    localparam int CORDIC_STEPS = 16;
    localparam int ATAN_LEN    = 24;
    localparam int CORDIC_ITERS = (CORDIC_STEPS < ATAN_LEN) ? CORDIC_STEPS : ATAN_LEN;
    localparam int DIVIDEND_W  = 55;
    localparam int DIVISOR_W   = 32;

    typedef logic [CFG_IDX_W-1:0] t_reg_idx;
    localparam t_reg_idx REG_INDUCTANCE = 3'd0;
    localparam t_reg_idx REG_RESISTANCE = 3'd1;
    localparam t_reg_idx REG_FLUX_LINK  = 3'd2;
    localparam t_reg_idx REG_GAIN       = 3'd3;
    localparam t_reg_idx REG_TIME_STEP  = 3'd4;

    typedef logic [3:0] t_op;
    localparam t_op OP_LIA    = 4'd0;
    localparam t_op OP_LIB    = 4'd1;
    localparam t_op OP_SQA    = 4'd2;
    localparam t_op OP_SQB    = 4'd3;
    localparam t_op OP_LAM2   = 4'd4;
    localparam t_op OP_TA     = 4'd5;
    localparam t_op OP_CA     = 4'd6;
    localparam t_op OP_RA     = 4'd7;
    localparam t_op OP_DXA    = 4'd8;
    localparam t_op OP_TB     = 4'd9;
    localparam t_op OP_CB     = 4'd10;
    localparam t_op OP_RB     = 4'd11;
    localparam t_op OP_DXB    = 4'd12;
    localparam t_op OP_DIVA   = 4'd13;
    localparam t_op OP_DIVB   = 4'd14;
    localparam t_op OP_CORDIC = 4'd15;

    typedef struct packed {
        logic load;
        logic start;
        t_op  op;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic done;
        logic out_busy;
    } t_stat;

    // Arctangent of 2^-k, with 2^31 equal to pi.
    function automatic logic [31:0] atan_unit(input logic [4:0] k);
        logic [31:0] v;
        case (k)
            5'd0:  v = 32'd536870912;
            5'd1:  v = 32'd316933406;
            5'd2:  v = 32'd167458907;
            5'd3:  v = 32'd85004756;
            5'd4:  v = 32'd42667331;
            5'd5:  v = 32'd21354465;
            5'd6:  v = 32'd10680862;
            5'd7:  v = 32'd5340245;
            5'd8:  v = 32'd2670163;
            5'd9:  v = 32'd1335087;
            5'd10: v = 32'd667544;
            5'd11: v = 32'd333772;
            5'd12: v = 32'd166886;
            5'd13: v = 32'd83443;
            5'd14: v = 32'd41722;
            5'd15: v = 32'd20861;
            5'd16: v = 32'd10430;
            5'd17: v = 32'd5215;
            5'd18: v = 32'd2608;
            5'd19: v = 32'd1304;
            5'd20: v = 32'd652;
            5'd21: v = 32'd326;
            5'd22: v = 32'd163;
            5'd23: v = 32'd81;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

/* src/nfo_in_if.sv */
// Input channel carrying one sample of currents and voltages.
interface nfo_in_if import nfo_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic signed [IN_W-1:0] current_alpha;
    logic signed [IN_W-1:0] current_beta;
    logic signed [IN_W-1:0] voltage_alpha;
    logic signed [IN_W-1:0] voltage_beta;

    modport source (output valid, current_alpha, current_beta, voltage_alpha, voltage_beta,
                    input ready);
    modport sink (input valid, current_alpha, current_beta, voltage_alpha, voltage_beta,
                  output ready);
endinterface

/* src/nfo_out_if.sv */
// Output channel carrying the angle and the normalized residuals.
interface nfo_out_if import nfo_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] rotor_angle;
    logic signed [OUT_W-1:0] cosine_estimate;
    logic signed [OUT_W-1:0] sine_estimate;

    modport source (output valid, rotor_angle, cosine_estimate, sine_estimate, input ready);
    modport sink (input valid, rotor_angle, cosine_estimate, sine_estimate, output ready);
endinterface

/* src/nfo_mul.sv */
// Shared 64x64 multiplier built from four 32x32 partial products, with sign.
module nfo_mul import nfo_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [63:0]  i_a,
    input  logic [63:0]  i_b,
    input  logic         i_neg,
    output logic         o_done,
    output logic [127:0] o_prod
);
    localparam logic [2:0] MUL_LAST = 3'd4;

    logic [63:0]  r_a, r_b;
    logic         r_neg, r_busy, r_done;
    logic [127:0] r_acc;
    logic [2:0]   r_cnt;
    logic [31:0]  w_ah, w_bh;
    logic [63:0]  w_pp;
    logic [1:0]   w_pos;
    logic [127:0] w_sh;

    assign w_ah  = r_cnt[1] ? r_a[63:32] : r_a[31:0];
    assign w_bh  = r_cnt[0] ? r_b[63:32] : r_b[31:0];
    assign w_pp  = w_ah * w_bh;
    assign w_pos = {1'b0, r_cnt[1]} + {1'b0, r_cnt[0]};
    assign w_sh  = {64'b0, w_pp} << {w_pos, 5'b0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 3'd0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_a    <= i_a;
                r_b    <= i_b;
                r_neg  <= i_neg;
                r_acc  <= '0;
                r_cnt  <= 3'd0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (r_cnt == MUL_LAST) begin
                    // The last cycle applies the sign to the finished magnitude.
                    r_acc  <= r_neg ? (~r_acc + 128'd1) : r_acc;
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_acc <= r_acc + w_sh;
                    r_cnt <= r_cnt + 3'd1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;
endmodule

/* src/nfo_div.sv */
// Restoring divider, one quotient bit per cycle.
module nfo_div import nfo_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [DIVIDEND_W-1:0] i_dividend,
    input  logic [DIVISOR_W-1:0]  i_divisor,
    output logic                  o_done,
    output logic [DIVIDEND_W-1:0] o_quot
);
    localparam logic [5:0] DIV_LAST = 6'(DIVIDEND_W - 1);

    logic [DIVIDEND_W-1:0] r_quo;
    logic [DIVISOR_W-1:0]  r_rem, r_dvs;
    logic [5:0]            r_cnt;
    logic                  r_busy, r_done;
    logic [DIVISOR_W:0]    w_trial, w_diff;
    logic                  w_ge;

    assign w_trial = {r_rem, r_quo[DIVIDEND_W-1]};
    assign w_ge    = w_trial >= {1'b0, r_dvs};
    assign w_diff  = w_trial - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 6'd0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_quo  <= i_dividend;
                r_rem  <= '0;
                r_dvs  <= i_divisor;
                r_cnt  <= 6'd0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem <= w_ge ? w_diff[DIVISOR_W-1:0] : w_trial[DIVISOR_W-1:0];
                r_quo <= {r_quo[DIVIDEND_W-2:0], w_ge};
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == DIV_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;
endmodule

/* src/nfo_ctrl.sv */
// Sequencer that steps the datapath through the operations of one sample.
module nfo_ctrl import nfo_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);
    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_ISSUE = 2'd1;
    localparam logic [1:0] S_WAIT  = 2'd2;
    localparam logic [1:0] S_EMIT  = 2'd3;

    logic [1:0] r_state, n_state;
    t_op        r_op, n_op;

    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_ISSUE;
                    n_op    = OP_LIA;
                end
            end
            S_ISSUE: n_state = S_WAIT;
            S_WAIT: begin
                if (i_stat.done) begin
                    if (r_op == OP_CORDIC) begin
                        n_state = S_EMIT;
                    end else begin
                        n_state = S_ISSUE;
                        n_op    = r_op + 4'd1;
                    end
                end
            end
            S_EMIT: begin
                if (!i_stat.out_busy) begin
                    n_state = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_op    <= OP_LIA;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cmd.load  = (r_state == S_IDLE) && i_in_valid;
    assign o_cmd.start = (r_state == S_ISSUE);
    assign o_cmd.op    = r_op;
    assign o_cmd.emit  = (r_state == S_EMIT) && !i_stat.out_busy;
endmodule

/* src/nfo_dp.sv */
// Datapath: registers, flux state, shared multiplier, divider and CORDIC.
module nfo_dp import nfo_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_cmd                    i_cmd,
    output t_stat                   o_stat,
    input  logic                    i_cfg_we,
    input  t_reg_idx                i_cfg_idx,
    input  logic [CFG_W-1:0]        i_cfg_data,
    input  logic signed [IN_W-1:0]  i_current_alpha,
    input  logic signed [IN_W-1:0]  i_current_beta,
    input  logic signed [IN_W-1:0]  i_voltage_alpha,
    input  logic signed [IN_W-1:0]  i_voltage_beta,
    input  logic                    i_out_ready,
    output logic                    o_out_valid,
    output logic signed [OUT_W-1:0] o_rotor_angle,
    output logic signed [OUT_W-1:0] o_cosine_estimate,
    output logic signed [OUT_W-1:0] o_sine_estimate
);
    localparam logic [4:0] CORDIC_LAST = 5'(CORDIC_ITERS - 1);

    function automatic logic signed [31:0] res_sat(input logic signed [40:0] e);
        logic signed [32:0] s;
        s = e[40:8];
        if (s > 33'sd2147483647) begin
            return 32'sh7FFFFFFF;
        end else if (s < -33'sd2147483647) begin
            return 32'sh80000001;
        end
        return s[31:0];
    endfunction

    function automatic logic signed [31:0] deriv_sat(input logic signed [IN_W-1:0] v,
                                                     input logic signed [31:0] ri,
                                                     input logic e_neg,
                                                     input logic [31:0] corr);
        logic signed [34:0] c, s;
        c = e_neg ? $signed({3'b0, corr}) : -$signed({3'b0, corr});
        s = 35'(v) - 35'(ri) + c;
        if (s > 35'sd2147483647) begin
            return 32'sh7FFFFFFF;
        end else if (s < -35'sd2147483647) begin
            return 32'sh80000001;
        end
        return s[31:0];
    endfunction

    function automatic logic signed [FLUX_W-1:0] flux_sat(input logic signed [48:0] s);
        if (s > 49'sd549755813887) begin
            return 40'sh7FFFFFFFFF;
        end else if (s < -49'sd549755813888) begin
            return 40'sh8000000000;
        end
        return s[FLUX_W-1:0];
    endfunction

    function automatic logic [OUT_W-1:0] q14_sat(input logic neg,
                                                 input logic [DIVIDEND_W-1:0] q);
        logic [DIVIDEND_W-1:0] nq;
        nq = ~q + 1'b1;
        if (neg) begin
            return (q > 55'd32768) ? 16'h8000 : nq[OUT_W-1:0];
        end
        return (q > 55'd32767) ? 16'h7FFF : q[OUT_W-1:0];
    endfunction

    // Configuration registers.
    logic [31:0] r_inductance, r_resistance, r_flux_link, r_time_step;
    logic [39:0] r_gain;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inductance <= 32'd0;
            r_resistance <= 32'd0;
            r_flux_link  <= 32'd1;
            r_gain       <= 40'd0;
            r_time_step  <= 32'd1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_INDUCTANCE: r_inductance <= i_cfg_data[31:0];
                REG_RESISTANCE: r_resistance <= i_cfg_data[31:0];
                REG_FLUX_LINK:  r_flux_link  <= i_cfg_data[31:0];
                REG_GAIN:       r_gain       <= i_cfg_data;
                REG_TIME_STEP:  r_time_step  <= i_cfg_data[31:0];
                default: ;
            endcase
        end
    end

    // Sample and working registers.
    logic signed [IN_W-1:0]   r_ia, r_ib, r_va, r_vb;
    logic signed [FLUX_W-1:0] r_lia, r_lib, r_flux_a, r_flux_b;
    logic signed [31:0]       r_ea24, r_eb24, r_d;
    logic [63:0]              r_sum, r_m, r_t;
    logic [31:0]              r_corr;
    logic [OUT_W-1:0]         r_cos, r_sin;

    logic [IN_W-1:0]   w_ia_mag, w_ib_mag;
    logic [31:0]       w_ea_mag, w_eb_mag, w_d_mag;
    logic signed [40:0] w_ea_fin, w_eb_fin;
    logic [40:0]       w_ea_fin_mag, w_eb_fin_mag;

    assign w_ia_mag = r_ia[IN_W-1] ? (~r_ia + 1'b1) : r_ia;
    assign w_ib_mag = r_ib[IN_W-1] ? (~r_ib + 1'b1) : r_ib;
    assign w_ea_mag = r_ea24[31] ? (~r_ea24 + 1'b1) : r_ea24;
    assign w_eb_mag = r_eb24[31] ? (~r_eb24 + 1'b1) : r_eb24;
    assign w_d_mag  = r_d[31] ? (~r_d + 1'b1) : r_d;
    assign w_ea_fin = {r_flux_a[FLUX_W-1], r_flux_a} - {r_lia[FLUX_W-1], r_lia};
    assign w_eb_fin = {r_flux_b[FLUX_W-1], r_flux_b} - {r_lib[FLUX_W-1], r_lib};
    assign w_ea_fin_mag = w_ea_fin[40] ? (~w_ea_fin + 1'b1) : w_ea_fin;
    assign w_eb_fin_mag = w_eb_fin[40] ? (~w_eb_fin + 1'b1) : w_eb_fin;

    // Shared multiplier operand selection.
    logic [63:0]  w_mul_a, w_mul_b;
    logic         w_mul_neg, w_mul_start, w_mul_done;
    logic [127:0] w_prod;

    always_comb begin
        w_mul_a   = '0;
        w_mul_b   = '0;
        w_mul_neg = 1'b0;
        unique case (i_cmd.op)
            OP_LIA: begin
                w_mul_a = 64'(r_inductance); w_mul_b = 64'(w_ia_mag); w_mul_neg = r_ia[IN_W-1];
            end
            OP_LIB: begin
                w_mul_a = 64'(r_inductance); w_mul_b = 64'(w_ib_mag); w_mul_neg = r_ib[IN_W-1];
            end
            OP_SQA: begin
                w_mul_a = 64'(w_ea_mag); w_mul_b = 64'(w_ea_mag);
            end
            OP_SQB: begin
                w_mul_a = 64'(w_eb_mag); w_mul_b = 64'(w_eb_mag);
            end
            OP_LAM2: begin
                w_mul_a = 64'(r_flux_link[31:8]); w_mul_b = 64'(r_flux_link[31:8]);
            end
            OP_TA: begin
                w_mul_a = 64'(w_ea_mag); w_mul_b = r_m;
            end
            OP_TB: begin
                w_mul_a = 64'(w_eb_mag); w_mul_b = r_m;
            end
            OP_CA, OP_CB: begin
                w_mul_a = r_t; w_mul_b = 64'(r_gain);
            end
            OP_RA: begin
                w_mul_a = 64'(r_resistance); w_mul_b = 64'(w_ia_mag); w_mul_neg = r_ia[IN_W-1];
            end
            OP_RB: begin
                w_mul_a = 64'(r_resistance); w_mul_b = 64'(w_ib_mag); w_mul_neg = r_ib[IN_W-1];
            end
            OP_DXA, OP_DXB: begin
                w_mul_a = 64'(w_d_mag); w_mul_b = 64'(r_time_step); w_mul_neg = r_d[31];
            end
            default: ;
        endcase
    end

    assign w_mul_start = i_cmd.start && (i_cmd.op < OP_DIVA);

    nfo_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul_start),
        .i_a     (w_mul_a),
        .i_b     (w_mul_b),
        .i_neg   (w_mul_neg),
        .o_done  (w_mul_done),
        .o_prod  (w_prod)
    );

    // Divider for the normalized residuals.
    logic                  w_div_start, w_div_done;
    logic [DIVIDEND_W-1:0] w_dividend, w_quot;
    logic [DIVISOR_W-1:0]  w_divisor;

    assign w_div_start = i_cmd.start && (i_cmd.op == OP_DIVA || i_cmd.op == OP_DIVB);
    assign w_dividend  = (i_cmd.op == OP_DIVA) ? {w_ea_fin_mag, 14'b0} : {w_eb_fin_mag, 14'b0};
    // A zero flux linkage divides as one LSB.
    assign w_divisor   = (r_flux_link == 32'd0) ? 32'd1 : r_flux_link;

    nfo_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_done     (w_div_done),
        .o_quot     (w_quot)
    );

    // Product slices used when storing results.
    logic signed [FLUX_W-1:0] w_lprod;
    logic signed [31:0]       w_ri, w_dnew;
    logic signed [47:0]       w_dx;
    logic signed [FLUX_W-1:0] w_flux_sel;
    logic [47:0]              w_lam2;
    logic [31:0]              w_corr_raw;
    logic                     w_corr_sat;

    assign w_lprod    = w_prod[55:16];
    assign w_ri       = w_prod[55:24];
    assign w_dx       = w_prod[63:16];
    assign w_lam2     = w_prod[47:0];
    assign w_corr_raw = w_prod[64:33];
    assign w_corr_sat = (|w_prod[127:65]) || (w_corr_raw > 32'h8000_0000);
    assign w_flux_sel = (i_cmd.op == OP_DXA) ? r_flux_a : r_flux_b;
    assign w_dnew     = (i_cmd.op == OP_RA) ? deriv_sat(r_va, w_ri, r_ea24[31], r_corr)
                                            : deriv_sat(r_vb, w_ri, r_eb24[31], r_corr);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flux_a <= '0;
            r_flux_b <= '0;
        end else begin
            if (i_cmd.load) begin
                r_ia <= i_current_alpha;
                r_ib <= i_current_beta;
                r_va <= i_voltage_alpha;
                r_vb <= i_voltage_beta;
            end
            if (w_mul_done) begin
                unique case (i_cmd.op)
                    OP_LIA: begin
                        r_lia  <= w_lprod;
                        r_ea24 <= res_sat({r_flux_a[FLUX_W-1], r_flux_a}
                                          - {w_lprod[FLUX_W-1], w_lprod});
                    end
                    OP_LIB: begin
                        r_lib  <= w_lprod;
                        r_eb24 <= res_sat({r_flux_b[FLUX_W-1], r_flux_b}
                                          - {w_lprod[FLUX_W-1], w_lprod});
                    end
                    OP_SQA:  r_sum <= w_prod[63:0];
                    OP_SQB:  r_sum <= r_sum + w_prod[63:0];
                    OP_LAM2: r_m   <= (r_sum > {16'b0, w_lam2}) ? (r_sum - {16'b0, w_lam2})
                                                                : 64'd0;
                    OP_TA, OP_TB: r_t <= (|w_prod[127:88]) ? '1 : w_prod[87:24];
                    OP_CA, OP_CB: r_corr <= w_corr_sat ? 32'h8000_0000 : w_corr_raw;
                    OP_RA, OP_RB: r_d <= w_dnew;
                    OP_DXA: r_flux_a <= flux_sat(49'(w_flux_sel) + 49'(w_dx));
                    OP_DXB: r_flux_b <= flux_sat(49'(w_flux_sel) + 49'(w_dx));
                    default: ;
                endcase
            end
            if (w_div_done) begin
                if (i_cmd.op == OP_DIVA) begin
                    r_cos <= q14_sat(w_ea_fin[40], w_quot);
                end else begin
                    r_sin <= q14_sat(w_eb_fin[40], w_quot);
                end
            end
        end
    end

    // CORDIC vectoring, one iteration per cycle.
    logic signed [43:0] r_cx, r_cy, w_xs, w_ys, w_x0, w_y0;
    logic [31:0]        r_acc, w_acc_rnd;
    logic [4:0]         r_k;
    logic               r_cbusy, r_czero, w_cdone;

    assign w_x0      = 44'(w_ea_fin);
    assign w_y0      = 44'(w_eb_fin);
    assign w_xs      = r_cx >>> r_k;
    assign w_ys      = r_cy >>> r_k;
    assign w_cdone   = r_cbusy && (r_k == CORDIC_LAST);
    assign w_acc_rnd = r_acc + 32'h0000_8000;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cbusy <= 1'b0;
            r_k     <= 5'd0;
        end else if (i_cmd.start && i_cmd.op == OP_CORDIC) begin
            r_czero <= (w_ea_fin == 41'sd0) && (w_eb_fin == 41'sd0);
            // A residual in the left half plane starts from the opposite vector.
            if (w_ea_fin[40]) begin
                r_cx  <= -w_x0;
                r_cy  <= -w_y0;
                r_acc <= 32'h8000_0000;
            end else begin
                r_cx  <= w_x0;
                r_cy  <= w_y0;
                r_acc <= 32'd0;
            end
            r_k     <= 5'd0;
            r_cbusy <= 1'b1;
        end else if (r_cbusy) begin
            if (!r_cy[43]) begin
                r_cx  <= r_cx + w_ys;
                r_cy  <= r_cy - w_xs;
                r_acc <= r_acc + atan_unit(r_k);
            end else begin
                r_cx  <= r_cx - w_ys;
                r_cy  <= r_cy + w_xs;
                r_acc <= r_acc - atan_unit(r_k);
            end
            r_k <= r_k + 5'd1;
            if (w_cdone) begin
                r_cbusy <= 1'b0;
            end
        end
    end

    // Output register.
    logic             r_out_valid;
    logic [OUT_W-1:0] r_angle_out, r_cos_out, r_sin_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
            r_angle_out <= r_czero ? 16'd0 : w_acc_rnd[31:16];
            r_cos_out   <= r_cos;
            r_sin_out   <= r_sin;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_stat.done     = w_mul_done || w_div_done || w_cdone;
    assign o_stat.out_busy = r_out_valid && !i_out_ready;
    assign o_out_valid       = r_out_valid;
    assign o_rotor_angle     = r_angle_out;
    assign o_cosine_estimate = r_cos_out;
    assign o_sine_estimate   = r_sin_out;
endmodule

/* src/nonlinear_flux_observer_top.sv */
// Top level of the nonlinear stator flux observer.
//
//  channel  direction  payload
//  i_in     sink       current_alpha, current_beta, voltage_alpha, voltage_beta
//  o_out    source     rotor_angle, cosine_estimate, sine_estimate
//  i_cfg_*  write      index 0..4, data up to 40 bits
//
// One sample passes through thirteen products on the shared 64x64 multiplier, two
// bit-serial divides and the CORDIC iterations, plus accept and emit. Reset is
// synchronous and needs no clearing pass.
// The next sample is taken while the previous result sits in the output register;
// a stalled output only holds the sequencer when the next result is ready to emit.
`include "nonlinear_flux_observer_top_macros.svh"
module nonlinear_flux_observer_top import nfo_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    nfo_in_if.sink           i_in,
    nfo_out_if.source        o_out,
    input  logic             i_cfg_we,
    input  t_reg_idx         i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_data
);
    t_cmd  w_cmd;
    t_stat w_stat;
    logic  w_in_ready;

    nfo_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (w_in_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    nfo_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .o_stat            (w_stat),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data),
        .i_current_alpha   (i_in.current_alpha),
        .i_current_beta    (i_in.current_beta),
        .i_voltage_alpha   (i_in.voltage_alpha),
        .i_voltage_beta    (i_in.voltage_beta),
        .i_out_ready       (o_out.ready),
        .o_out_valid       (o_out.valid),
        .o_rotor_angle     (o_out.rotor_angle),
        .o_cosine_estimate (o_out.cosine_estimate),
        .o_sine_estimate   (o_out.sine_estimate)
    );

    assign i_in.ready = w_in_ready;

    `NFO_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in.valid && w_in_ready, !w_in_ready)
    `NFO_ASSERT_NOW(a_start_while_busy, i_clk, i_rst_n, w_cmd.start, !w_in_ready)
    `NFO_ASSERT_NOW(a_done_not_at_start, i_clk, i_rst_n, w_stat.done, !w_cmd.start)
    `NFO_ASSERT_NEXT(a_emit_fills_output, i_clk, i_rst_n, w_cmd.emit, o_out.valid)
endmodule

/* test/tb.sv */
// Self-checking testbench for the nonlinear flux observer top level.
module tb;
    import nfo_pkg::*;

    typedef struct packed {
        logic signed [IN_W-1:0] cur_a;
        logic signed [IN_W-1:0] cur_b;
        logic signed [IN_W-1:0] volt_a;
        logic signed [IN_W-1:0] volt_b;
    } t_sample;

    typedef struct packed {
        logic signed [OUT_W-1:0] angle;
        logic signed [OUT_W-1:0] cos_est;
        logic signed [OUT_W-1:0] sin_est;
    } t_estimate;

    typedef struct packed {
        logic             is_cfg;
        t_reg_idx         idx;
        logic [CFG_W-1:0] data;
        t_sample          smp;
        logic             typed;
        t_estimate        want;
    } t_row;

    localparam longint DERIV_MAX = 64'sd2147483647;
    localparam longint FLUX_HI   = 64'sd549755813887;
    localparam longint FLUX_LO   = -64'sd549755813888;
    localparam int     SETTLE    = 300;
    localparam int     STALL_LIMIT = 6000;
    localparam int     N_PHASES  = 10;
    localparam int     PHASE_ITEMS = 185;
    localparam logic signed [IN_W-1:0] IN_MAX = 24'sh7FFFFF;
    localparam logic signed [IN_W-1:0] IN_MIN = 24'sh800000;

    localparam logic [31:0] ARCTAN [0:23] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
        32'd21354465, 32'd10680862, 32'd5340245, 32'd2670163, 32'd1335087,
        32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
        32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81};

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    t_reg_idx i_cfg_idx;
    logic [CFG_W-1:0] i_cfg_data;

    nfo_in_if  in_ch();
    nfo_out_if out_ch();

    nonlinear_flux_observer_top uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch.sink),
        .o_out      (out_ch.source),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // Shadow registers and flux state of the predictor.
    longint l_ind, l_res, l_lam, l_gain, l_dt;
    longint flux_a, flux_b;

    t_estimate pending_q[$];
    t_row      cur_row;
    int        err_cnt;
    int        idle_cycles;
    t_row      directed[$];

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic longint clip(longint v, longint lo, longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic logic [OUT_W-1:0] to_q14(longint e, longint lam);
        longint q;
        q = clip((e * 16384) / lam, -32768, 32767);
        return q[OUT_W-1:0];
    endfunction

    function automatic logic [OUT_W-1:0] vector_angle(longint x, longint y);
        logic [31:0] acc;
        longint      xs, ys;
        int          iters;
        acc = 32'd0;
        iters = (CORDIC_STEPS < 24) ? CORDIC_STEPS : 24;
        if (x == 0 && y == 0) return '0;
        if (x < 0) begin
            x = -x;
            y = -y;
            acc = 32'h8000_0000;
        end
        for (int k = 0; k < iters; k++) begin
            xs = x >>> k;
            ys = y >>> k;
            if (y >= 0) begin
                x += ys;
                y -= xs;
                acc += ARCTAN[k];
            end else begin
                x -= ys;
                y += xs;
                acc -= ARCTAN[k];
            end
        end
        acc = acc + 32'h8000;
        return acc[31:16];
    endfunction

    // Advances the flux estimates by one sample and returns the new estimate.
    function automatic t_estimate track_flux(t_sample s);
        longint      cur[2], volt[2], e24[2], drv[2], li_a, li_b, ea, eb, lam, ri, corr, dx;
        logic [63:0] sum, lam2, m, mag;
        logic [127:0] prod, t;
        t_estimate   r;
        cur[0] = s.cur_a;
        cur[1] = s.cur_b;
        volt[0] = s.volt_a;
        volt[1] = s.volt_b;
        li_a = (l_ind * cur[0]) >>> 16;
        li_b = (l_ind * cur[1]) >>> 16;
        ea = flux_a - li_a;
        eb = flux_b - li_b;
        e24[0] = clip(ea >>> 8, -DERIV_MAX, DERIV_MAX);
        e24[1] = clip(eb >>> 8, -DERIV_MAX, DERIV_MAX);
        lam2 = (l_lam >> 8) * (l_lam >> 8);
        sum = 64'(e24[0] * e24[0]) + 64'(e24[1] * e24[1]);
        m = (sum > lam2) ? sum - lam2 : 64'd0;
        lam = (l_lam == 0) ? 1 : l_lam;
        for (int c = 0; c < 2; c++) begin
            mag = (e24[c] < 0) ? 64'(-e24[c]) : 64'(e24[c]);
            prod = {64'd0, mag} * {64'd0, m};
            t = prod >> 24;
            if (t[127:64] != 0) t = {64'd0, {64{1'b1}}};
            prod = {64'd0, t[63:0]} * {88'd0, l_gain[39:0]};
            prod = prod >> 33;
            corr = (prod > 128'd2147483648) ? 64'sd2147483648 : longint'(prod[63:0]);
            ri = (l_res * cur[c]) >>> 24;
            drv[c] = clip(volt[c] - ri + ((e24[c] < 0) ? corr : -corr),
                          -DERIV_MAX, DERIV_MAX);
        end
        dx = (drv[0] * l_dt) >>> 16;
        flux_a = clip(flux_a + dx, FLUX_LO, FLUX_HI);
        dx = (drv[1] * l_dt) >>> 16;
        flux_b = clip(flux_b + dx, FLUX_LO, FLUX_HI);
        ea = flux_a - li_a;
        eb = flux_b - li_b;
        r.angle = vector_angle(ea, eb);
        r.cos_est = to_q14(ea, lam);
        r.sin_est = to_q14(eb, lam);
        return r;
    endfunction

    task automatic report(string what, logic [OUT_W-1:0] got, logic [OUT_W-1:0] want);
        $display("mismatch %s: got %0d expected %0d at %0t",
                 what, $signed(got), $signed(want), $realtime);
        err_cnt++;
    endtask

    // Transaction monitor, checker and watchdog.
    always @(posedge i_clk) begin
        t_estimate exp_r, p;
        if (i_rst_n) begin
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (in_ch.valid && in_ch.ready) begin
                p = track_flux(cur_row.smp);
                pending_q.push_back(cur_row.typed ? cur_row.want : p);
            end
            if (out_ch.valid && out_ch.ready) begin
                if (pending_q.size() == 0) begin
                    $display("unexpected transaction on the output at %0t", $realtime);
                    err_cnt++;
                end else begin
                    exp_r = pending_q.pop_front();
                    if (out_ch.rotor_angle !== exp_r.angle)
                        report("rotor_angle", out_ch.rotor_angle, exp_r.angle);
                    if (out_ch.cosine_estimate !== exp_r.cos_est)
                        report("cosine_estimate", out_ch.cosine_estimate, exp_r.cos_est);
                    if (out_ch.sine_estimate !== exp_r.sin_est)
                        report("sine_estimate", out_ch.sine_estimate, exp_r.sin_est);
                end
            end
            if (idle_cycles >= STALL_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // Output back-pressure: long ready runs, random toggling and long stalls.
    int rdy_run;
    int rdy_mode;
    always @(negedge i_clk) begin
        if (rdy_run == 0) begin
            rdy_mode = $urandom_range(0, 2);
            rdy_run = (rdy_mode == 2) ? $urandom_range(1, 600) : $urandom_range(100, 3000);
        end
        rdy_run--;
        case (rdy_mode)
            0: out_ch.ready <= 1'b1;
            1: out_ch.ready <= 1'($urandom_range(0, 1));
            default: out_ch.ready <= (rdy_run < 3);
        endcase
    end

    task automatic write_reg(t_reg_idx idx, logic [CFG_W-1:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            REG_INDUCTANCE: l_ind = data[31:0];
            REG_RESISTANCE: l_res = data[31:0];
            REG_FLUX_LINK:  l_lam = data[31:0];
            REG_GAIN:       l_gain = data[39:0];
            REG_TIME_STEP:  l_dt = data[31:0];
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    // Waits until every result is back and the sequencer has drained.
    task automatic wait_idle();
        while (pending_q.size() != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    int burst_left;

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_sample(t_row r);
        if (burst_left == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 40)) @(negedge i_clk);
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        cur_row <= r;
        in_ch.valid <= 1'b1;
        in_ch.current_alpha <= r.smp.cur_a;
        in_ch.current_beta <= r.smp.cur_b;
        in_ch.voltage_alpha <= r.smp.volt_a;
        in_ch.voltage_beta <= r.smp.volt_b;
        do @(posedge i_clk); while (!in_ch.ready);
        @(negedge i_clk);
    endtask

    function automatic t_row sample_row(logic signed [IN_W-1:0] ia, logic signed [IN_W-1:0] ib,
                                        logic signed [IN_W-1:0] va, logic signed [IN_W-1:0] vb,
                                        logic typed);
        t_row r;
        r = '0;
        r.smp = '{ia, ib, va, vb};
        r.typed = typed;
        return r;
    endfunction

    function automatic t_row reg_row(t_reg_idx idx, logic [CFG_W-1:0] data);
        t_row r;
        r = '0;
        r.is_cfg = 1'b1;
        r.idx = idx;
        r.data = data;
        return r;
    endfunction

    function automatic logic signed [IN_W-1:0] rand_field(int scale);
        logic signed [IN_W-1:0] v;
        v = IN_W'($urandom);
        return (scale == 0) ? v : (v >>> scale);
    endfunction

    initial begin
        t_row r;
        int profile, scale_i, scale_v;
        in_ch.valid = 1'b0;
        in_ch.current_alpha = '0;
        in_ch.current_beta = '0;
        in_ch.voltage_alpha = '0;
        in_ch.voltage_beta = '0;
        out_ch.ready = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = REG_INDUCTANCE;
        i_cfg_data = '0;
        cur_row = '0;
        err_cnt = 0;
        idle_cycles = 0;
        rdy_run = 0;
        burst_left = 0;
        l_ind = 0;
        l_res = 0;
        l_lam = 1;
        l_gain = 0;
        l_dt = 1;
        flux_a = 0;
        flux_b = 0;
        i_rst_n = 1'b0;

        // With reset values the residual stays zero while the voltages are zero.
        directed.push_back(sample_row('0, '0, '0, '0, 1'b1));
        directed.push_back(sample_row(IN_MAX, IN_MIN, '0, '0, 1'b1));
        directed.push_back(sample_row(IN_MIN, IN_MAX, '0, '0, 1'b1));
        directed.push_back(sample_row('0, '0, IN_MAX, IN_MIN, 1'b0));
        directed.push_back(sample_row('0, '0, IN_MIN, IN_MAX, 1'b0));
        // A zero time step freezes the flux estimates.
        directed.push_back(reg_row(REG_TIME_STEP, '0));
        directed.push_back(sample_row(IN_MAX, IN_MAX, IN_MAX, IN_MAX, 1'b0));
        directed.push_back(sample_row(IN_MIN, IN_MIN, IN_MIN, IN_MIN, 1'b0));
        // Every register at its top value, and a zero flux linkage.
        directed.push_back(reg_row(REG_INDUCTANCE, 40'hFFFF_FFFF));
        directed.push_back(reg_row(REG_RESISTANCE, 40'hFFFF_FFFF));
        directed.push_back(reg_row(REG_FLUX_LINK, '0));
        directed.push_back(reg_row(REG_GAIN, {CFG_W{1'b1}}));
        directed.push_back(reg_row(REG_TIME_STEP, 40'hFFFF_FFFF));
        directed.push_back(sample_row(IN_MAX, IN_MIN, IN_MAX, IN_MIN, 1'b0));
        directed.push_back(sample_row(IN_MIN, IN_MAX, IN_MIN, IN_MAX, 1'b0));
        directed.push_back(sample_row('0, '0, '0, '0, 1'b0));
        directed.push_back(sample_row(-24'sd1, 24'sd1, -24'sd1, 24'sd1, 1'b0));
        directed.push_back(reg_row(REG_FLUX_LINK, 40'hFFFF_FFFF));
        directed.push_back(sample_row(IN_MAX, IN_MAX, IN_MIN, IN_MIN, 1'b0));
        directed.push_back(sample_row('0, '0, '0, '0, 1'b0));
        // A motor-like setting where the observer correction is active.
        directed.push_back(reg_row(REG_INDUCTANCE, 40'd4294967));
        directed.push_back(reg_row(REG_RESISTANCE, 40'd8388608));
        directed.push_back(reg_row(REG_FLUX_LINK, 40'd268435456));
        directed.push_back(reg_row(REG_GAIN, 40'd1000000));
        directed.push_back(reg_row(REG_TIME_STEP, 40'd214748));
        for (int k = 0; k < 8; k++)
            directed.push_back(sample_row(IN_W'(24'sd65536 * k), IN_W'(-24'sd32768 * k),
                                          IN_W'(24'sd262144 * k), IN_W'(IN_MIN + k), 1'b0));

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed[n]) begin
            if (directed[n].is_cfg) begin
                if (in_ch.valid) begin
                    in_ch.valid <= 1'b0;
                    burst_left = 0;
                end
                wait_idle();
                write_reg(directed[n].idx, directed[n].data);
                i_cfg_we <= 1'b0;
                @(negedge i_clk);
            end else begin
                send_sample(directed[n]);
            end
        end

        for (int ph = 0; ph < N_PHASES; ph++) begin
            in_ch.valid <= 1'b0;
            burst_left = 0;
            wait_idle();
            profile = (ph == N_PHASES - 1) ? 3 : ph % 4;
            case (profile)
                0: begin
                    write_reg(REG_INDUCTANCE, CFG_W'($urandom_range(1000000, 20000000)));
                    write_reg(REG_RESISTANCE, CFG_W'($urandom_range(1000000, 30000000)));
                    write_reg(REG_FLUX_LINK, CFG_W'($urandom_range(50000000, 800000000)));
                    write_reg(REG_GAIN, CFG_W'($urandom_range(0, 1 << 24)));
                    write_reg(REG_TIME_STEP, CFG_W'($urandom_range(50000, 500000)));
                end
                1: begin
                    write_reg(REG_INDUCTANCE, CFG_W'($urandom));
                    write_reg(REG_RESISTANCE, CFG_W'($urandom));
                    write_reg(REG_FLUX_LINK, CFG_W'($urandom));
                    write_reg(REG_GAIN, CFG_W'({$urandom, $urandom}));
                    write_reg(REG_TIME_STEP, CFG_W'($urandom));
                end
                2: begin
                    write_reg(REG_INDUCTANCE, CFG_W'($urandom_range(0, 30000000)));
                    write_reg(REG_RESISTANCE, CFG_W'($urandom_range(0, 1 << 26)));
                    write_reg(REG_FLUX_LINK, CFG_W'($urandom_range(1, 1 << 20)));
                    write_reg(REG_GAIN, CFG_W'({$urandom_range(0, 255), $urandom}));
                    write_reg(REG_TIME_STEP, CFG_W'($urandom_range(1, 1 << 22)));
                end
                default: begin
                    write_reg(REG_INDUCTANCE, '0);
                    write_reg(REG_RESISTANCE, '0);
                    write_reg(REG_FLUX_LINK, 40'd1);
                    write_reg(REG_GAIN, '0);
                    write_reg(REG_TIME_STEP, 40'd1);
                end
            endcase
            i_cfg_we <= 1'b0;
            @(negedge i_clk);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // Mostly moderate signals so the flux tracks a real trajectory.
                scale_i = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(2, 8);
                scale_v = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                r = sample_row(rand_field(scale_i), rand_field(scale_i),
                               rand_field(scale_v), rand_field(scale_v), 1'b0);
                send_sample(r);
            end
        end

        in_ch.valid <= 1'b0;
        wait_idle();
        if (err_cnt == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
